/* hdl/utf8sd_pkg.sv */
// Package: shared constants, byte classes and queue word type of the UTF-8 decoder.
package utf8sd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CP_BITS    = 21;
  localparam int LEN_BITS   = 3;
  localparam int STAT_BITS  = 2;
  localparam int CNT_OUT_W  = 16;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } kind_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LEAD = 2'd1,
    STAT_TRUNC    = 2'd2
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] lead_bits;
    logic [5:0] cont_bits;
    logic       eos;
  } word_t;

endpackage

/* hdl/utf8sd_in_if.sv */
// Interface: byte input channel.
interface utf8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

/* hdl/utf8sd_out_if.sv */
// Interface: decoded character result channel.
interface utf8sd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  seq_bytes;
  logic [1:0]  status;
  logic [15:0] char_count;
  logic        string_done;

  modport source (output valid, output code_point, output seq_bytes, output status,
                  output char_count, output string_done, input ready);
  modport sink (input valid, input code_point, input seq_bytes, input status,
                input char_count, input string_done, output ready);
endinterface

/* hdl/utf8sd_front.sv */
// Front end: byte classification and the word queue towards the back end.
module utf8sd_front
  import utf8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  output logic       q_valid,
  input  logic       q_pop,
  output word_t      q_word
);

  word_t                cls_word;
  word_t                q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 push;
  logic                 pop;

  always_comb begin
    cls_word.eos       = in_eos;
    cls_word.cont_bits = in_byte[5:0];
    cls_word.lead_bits = 7'd0;
    if (!in_byte[7]) begin
      cls_word.kind      = KIND_ASCII;
      cls_word.lead_bits = in_byte[6:0];
    end else if (in_byte[6:5] == 2'b10) begin
      cls_word.kind      = KIND_LEAD2;
      cls_word.lead_bits = {2'b00, in_byte[4:0]};
    end else if (in_byte[6:4] == 3'b110) begin
      cls_word.kind      = KIND_LEAD3;
      cls_word.lead_bits = {3'b000, in_byte[3:0]};
    end else if (in_byte[6:3] == 4'b1110) begin
      cls_word.kind      = KIND_LEAD4;
      cls_word.lead_bits = {4'b0000, in_byte[2:0]};
    end else begin
      cls_word.kind = KIND_BAD;
    end
  end

  assign in_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_word   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_word;
    end
  end

endmodule

/* hdl/utf8sd_back.sv */
// Back end: sequence state, character count and the result register.
module utf8sd_back
  import utf8sd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  word_t                q_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CP_BITS-1:0]   out_code_point,
  output logic [LEN_BITS-1:0]  out_seq_bytes,
  output logic [STAT_BITS-1:0] out_status,
  output logic [CNT_OUT_W-1:0] out_char_count,
  output logic                 out_string_done
);

  logic [1:0]             bytes_left_r, bytes_left_nxt;
  logic [LEN_BITS-1:0]    seq_total_r, seq_total_nxt;
  logic [CP_BITS-1:0]     accum_r, accum_nxt;
  logic [COUNT_BITS-1:0]  chars_r, chars_nxt;
  logic                   discard_r, discard_nxt;
  logic                   valid_r, valid_nxt;
  logic [CP_BITS-1:0]     cp_r, cp_nxt;
  logic [LEN_BITS-1:0]    len_r, len_nxt;
  status_t                stat_r, stat_nxt;
  logic [CNT_OUT_W-1:0]   cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;

  logic                   take;
  logic                   emit;
  logic                   end_str;
  logic [COUNT_BITS-1:0]  chars_inc;
  logic [CP_BITS-1:0]     acc_shift;
  logic [1:0]             left_dec;

  assign q_pop     = !valid_r || out_ready;
  assign take      = q_valid && q_pop;
  assign chars_inc = (chars_r == '1) ? chars_r : chars_r + 1'b1;
  assign acc_shift = {accum_r[CP_BITS-7:0], q_word.cont_bits};
  assign left_dec  = bytes_left_r - 2'd1;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seq_total_nxt  = seq_total_r;
    accum_nxt      = accum_r;
    chars_nxt      = chars_r;
    discard_nxt    = discard_r;
    emit           = 1'b0;
    end_str        = 1'b0;
    cp_nxt         = '0;
    len_nxt        = '0;
    stat_nxt       = STAT_OK;
    cnt_nxt        = CNT_OUT_W'(chars_r);
    done_nxt       = q_word.eos;
    if (take) begin
      if (discard_r) begin
        end_str = q_word.eos;
      end else if (bytes_left_r == 2'd0) begin
        case (q_word.kind)
          KIND_ASCII: begin
            emit      = 1'b1;
            chars_nxt = chars_inc;
            cnt_nxt   = CNT_OUT_W'(chars_inc);
            cp_nxt    = CP_BITS'(q_word.lead_bits);
            len_nxt   = LEN_BITS'(1);
            end_str   = q_word.eos;
          end
          KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
            if (q_word.eos) begin
              emit     = 1'b1;
              stat_nxt = STAT_TRUNC;
              end_str  = 1'b1;
            end else begin
              accum_nxt = CP_BITS'(q_word.lead_bits);
              case (q_word.kind)
                KIND_LEAD2: begin
                  seq_total_nxt  = LEN_BITS'(2);
                  bytes_left_nxt = 2'd1;
                end
                KIND_LEAD3: begin
                  seq_total_nxt  = LEN_BITS'(3);
                  bytes_left_nxt = 2'd2;
                end
                default: begin
                  seq_total_nxt  = LEN_BITS'(4);
                  bytes_left_nxt = 2'd3;
                end
              endcase
            end
          end
          default: begin
            emit     = 1'b1;
            stat_nxt = STAT_BAD_LEAD;
            done_nxt = 1'b1;
            if (q_word.eos) begin
              end_str = 1'b1;
            end else begin
              discard_nxt = 1'b1;
            end
          end
        endcase
      end else begin
        accum_nxt      = acc_shift;
        bytes_left_nxt = left_dec;
        if (left_dec == 2'd0) begin
          emit          = 1'b1;
          chars_nxt     = chars_inc;
          cnt_nxt       = CNT_OUT_W'(chars_inc);
          cp_nxt        = acc_shift;
          len_nxt       = seq_total_r;
          accum_nxt     = '0;
          seq_total_nxt = '0;
          end_str       = q_word.eos;
        end else if (q_word.eos) begin
          emit     = 1'b1;
          stat_nxt = STAT_TRUNC;
          end_str  = 1'b1;
        end
      end
      if (end_str) begin
        bytes_left_nxt = '0;
        seq_total_nxt  = '0;
        accum_nxt      = '0;
        chars_nxt      = '0;
        discard_nxt    = 1'b0;
      end
    end
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      seq_total_r  <= '0;
      accum_r      <= '0;
      chars_r      <= '0;
      discard_r    <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      seq_total_r  <= seq_total_nxt;
      accum_r      <= accum_nxt;
      chars_r      <= chars_nxt;
      discard_r    <= discard_nxt;
      valid_r      <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r   <= cp_nxt;
      len_r  <= len_nxt;
      stat_r <= stat_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_code_point  = cp_r;
  assign out_seq_bytes   = len_r;
  assign out_status      = stat_r;
  assign out_char_count  = cnt_r;
  assign out_string_done = done_r;

endmodule

/* hdl/utf8_stream_decoder.sv */
// Top level: UTF-8 stream decoder, classifying front end, queue and decoding back end.
//
//   channel   dir   word                                                  accepted when
//   in_ch     in    data_byte, end_of_string                              valid && ready
//   out_ch    out   code_point, seq_bytes, status, char_count, string_done valid && ready
//
// One byte per clock sustained while the output is not stalled; a byte is written into
// the two-entry queue and its result is held in the result register of the back end.
// Reset clears the queue, the sequence state, the count and the result valid.
// A stalled output holds its result while the queue still takes up to two bytes.
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  utf8sd_in_if.sink    in_ch,
  utf8sd_out_if.source out_ch
);

  logic  q_valid;
  logic  q_pop;
  word_t q_word;

  utf8sd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .in_eos   (in_ch.end_of_string),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_word   (q_word)
  );

  utf8sd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_word          (q_word),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_code_point  (out_ch.code_point),
    .out_seq_bytes   (out_ch.seq_bytes),
    .out_status      (out_ch.status),
    .out_char_count  (out_ch.char_count),
    .out_string_done (out_ch.string_done)
  );

endmodule
